// ----- hdl/psm_pkg.sv -----
`default_nettype none

package psm_pkg;

    // fixed widths of the stream words
    localparam int PSM_WORD_W       = 64;
    localparam int PSM_QUBITS_DEF   = 64;
    localparam int PSM_PHASE_W      = 2;
    localparam int PSM_IN_TDATA_W   = 264;
    localparam int PSM_OUT_TDATA_W  = 136;
    localparam int PSM_POP_LEVELS   = $clog2(PSM_WORD_W);

    typedef logic [PSM_PHASE_W-1:0] t_phase;

    // control from the datapath to the phase accumulator
    typedef struct packed {
        logic advance;
        logic last;
    } t_acc_ctrl;

    // population count modulo 4 as a balanced adder tree of 2-bit sums
    function automatic t_phase pop_mod4(input logic [PSM_WORD_W-1:0] v);
        t_phase s [PSM_WORD_W];
        for (int k = 0; k < PSM_WORD_W; k++) begin
            s[k] = {1'b0, v[k]};
        end
        for (int lvl = 0; lvl < PSM_POP_LEVELS; lvl++) begin
            for (int k = 0; k < (PSM_WORD_W >> (lvl + 1)); k++) begin
                s[k] = s[2*k] + s[2*k+1];
            end
        end
        return s[0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pauli_string_multiply_phase.sv -----
// path: input stage, then output stage; s_axis_tready follows m_axis_tready while both are full
// throughput: one word per cycle while m_axis_tready does not stall the stages
// phase: a 2-bit accumulator carries the running power of i from word to word
// reset: synchronous, active low; empties both stages, clears the phase, arms first word
`default_nettype none

module pauli_string_multiply_phase
    import psm_pkg::*;
#(
    parameter int QUBITS_PER_WORD = PSM_QUBITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // left_x, left_z, right_x, right_z, left_phase, right_phase, zero pad
    input  wire logic [PSM_IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic                       s_axis_tlast,
    // product_x, product_z, phase, zero pad
    output logic      [PSM_OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic                            m_axis_tlast
);

    localparam int Q = QUBITS_PER_WORD;

    // input stage
    logic         r_a_valid;
    logic [Q-1:0] r_lx, r_lz, r_rx, r_rz;
    t_phase       r_lp, r_rp;
    logic         r_a_last;

    // output stage
    logic         r_b_valid;
    logic [Q-1:0] r_px, r_pz;
    t_phase       r_phase;
    logic         r_b_last;

    logic         w_b_free;
    logic         w_advance;
    logic         w_take;
    logic [Q-1:0] w_px, w_pz;
    t_phase       w_inc;
    t_phase       w_phase;
    t_acc_ctrl    w_ctrl;

    // handshake between the stages
    assign w_b_free      = !r_b_valid || m_axis_tready;
    assign w_advance     = r_a_valid && w_b_free;
    assign s_axis_tready = !r_a_valid || w_b_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_a_valid <= 1'b1;
            end else if (w_advance) begin
                r_a_valid <= 1'b0;
            end
            if (w_advance) begin
                r_b_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // input register, only the live qubit lanes are kept
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_lx     <= s_axis_tdata[0 +: Q];
            r_lz     <= s_axis_tdata[PSM_WORD_W +: Q];
            r_rx     <= s_axis_tdata[2*PSM_WORD_W +: Q];
            r_rz     <= s_axis_tdata[3*PSM_WORD_W +: Q];
            r_lp     <= s_axis_tdata[4*PSM_WORD_W +: PSM_PHASE_W];
            r_rp     <= s_axis_tdata[4*PSM_WORD_W+PSM_PHASE_W +: PSM_PHASE_W];
            r_a_last <= s_axis_tlast;
        end
    end

    psm_word_logic #(
        .QUBITS_PER_WORD(QUBITS_PER_WORD)
    ) u_word (
        .i_lx  (r_lx),
        .i_lz  (r_lz),
        .i_rx  (r_rx),
        .i_rz  (r_rz),
        .o_px  (w_px),
        .o_pz  (w_pz),
        .o_inc (w_inc)
    );

    assign w_ctrl.advance = w_advance;
    assign w_ctrl.last    = r_a_last;

    psm_phase_acc u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_left_phase  (r_lp),
        .i_right_phase (r_rp),
        .i_inc         (w_inc),
        .o_phase       (w_phase)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_px     <= w_px;
            r_pz     <= w_pz;
            r_phase  <= w_phase;
            r_b_last <= r_a_last;
        end
    end

    // output packing, unused lanes read as zero
    assign m_axis_tdata = {(PSM_OUT_TDATA_W - 2*PSM_WORD_W - PSM_PHASE_W)'(0), r_phase,
                           PSM_WORD_W'(r_pz), PSM_WORD_W'(r_px)};
    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tlast  = r_b_last;

endmodule

`default_nettype wire

// ----- hdl/psm_word_logic.sv -----
`default_nettype none

module psm_word_logic
    import psm_pkg::*;
#(
    parameter int QUBITS_PER_WORD = PSM_QUBITS_DEF
) (
    input  wire logic [QUBITS_PER_WORD-1:0] i_lx,
    input  wire logic [QUBITS_PER_WORD-1:0] i_lz,
    input  wire logic [QUBITS_PER_WORD-1:0] i_rx,
    input  wire logic [QUBITS_PER_WORD-1:0] i_rz,
    output logic      [QUBITS_PER_WORD-1:0] o_px,
    output logic      [QUBITS_PER_WORD-1:0] o_pz,
    output t_phase                          o_inc
);

    logic [QUBITS_PER_WORD-1:0] w_l;
    logic [QUBITS_PER_WORD-1:0] w_h;
    t_phase                     w_l_cnt;

    // product masks
    assign o_px = i_lx ^ i_rx;
    assign o_pz = i_lz ^ i_rz;

    // lanes where both operands are non-identity and differ
    assign w_l = (i_lx | i_lz) & (i_rx | i_rz) & (o_px | o_pz);
    assign w_h = ((i_rz & i_lx) ^ (o_pz & o_px)) & w_l;

    // 2*popcount(h) mod 4 only needs the parity of h
    assign w_l_cnt = pop_mod4(PSM_WORD_W'(w_l));
    assign o_inc   = w_l_cnt + {^w_h, 1'b0};

endmodule

`default_nettype wire

// ----- hdl/psm_phase_acc.sv -----
`default_nettype none

module psm_phase_acc
    import psm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_acc_ctrl i_ctrl,
    input  wire t_phase    i_left_phase,
    input  wire t_phase    i_right_phase,
    input  wire t_phase    i_inc,
    output t_phase         o_phase
);

    t_phase r_acc;
    logic   r_first;
    t_phase n_acc;
    logic   n_first;
    t_phase w_base;

    // a new product starts from the sum of the operand phases
    assign w_base  = r_first ? (i_left_phase + i_right_phase) : r_acc;
    assign o_phase = w_base + i_inc;

    // next state
    always_comb begin
        n_acc   = r_acc;
        n_first = r_first;
        if (i_ctrl.advance) begin
            n_acc   = o_phase;
            n_first = i_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_first <= 1'b1;
        end else begin
            r_acc   <= n_acc;
            r_first <= n_first;
        end
    end

`ifndef SYNTHESIS
    // a last word reopens the product
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.advance && i_ctrl.last) |=> r_first)
        else $error("first-word flag not set after last word");

    // an inner word keeps the product open and stores the new phase
    a_inner_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.advance && !i_ctrl.last) |=> (!r_first && r_acc == $past(o_phase)))
        else $error("accumulator not updated on inner word");

    // state holds while no word moves
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.advance |=> ($stable(r_acc) && $stable(r_first)))
        else $error("phase state changed without a word");
`endif

endmodule

`default_nettype wire
